// ===== design/gb3_pkg.sv =====
package gb3_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int BLUR_BITS  = 12;
    localparam int CFG_BITS   = 11;
    localparam int SHIFT_BITS = 4;
    localparam int ROW_BITS   = 11;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHIFT_AMOUNT = 2'd2;

    localparam logic [CFG_BITS-1:0]   RESET_FRAME_WIDTH  = 11'd1024;
    localparam logic [CFG_BITS-1:0]   RESET_FRAME_HEIGHT = 11'd1024;
    localparam logic [SHIFT_BITS-1:0] RESET_SHIFT_AMOUNT = 4'd4;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam int QDEPTH = 8;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                  action;
        logic [PIXEL_BITS-1:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic [BLUR_BITS-1:0] blurred;
        logic                 row_end;
        logic                 frame_end;
        logic                 run_last;
    } t_out_item;

    typedef struct packed {
        logic      v0;
        t_out_item r0;
        logic      v1;
        t_out_item r1;
    } t_push;

endpackage

// ===== design/gb3_linemem.sv =====
module gb3_linemem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gb3_outq.sv =====
module gb3_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gb3_pkg::t_push       i_push,
    output logic                 o_valid,
    input  logic                 i_stall,
    output gb3_pkg::t_out_item   o_item,
    output logic [gb3_pkg::QCW-1:0] o_count
);

    gb3_pkg::t_out_item           r_q [gb3_pkg::QDEPTH];
    logic [gb3_pkg::QPW-1:0]      r_wp;
    logic [gb3_pkg::QPW-1:0]      r_rp;
    logic [gb3_pkg::QCW-1:0]      r_count;
    logic [gb3_pkg::QPW-1:0]      n_wp;
    logic [gb3_pkg::QPW-1:0]      n_rp;
    logic [gb3_pkg::QCW-1:0]      n_count;
    logic [gb3_pkg::QPW-1:0]      wp1;
    logic                         pop;
    logic [1:0]                   npush;

    assign o_valid = (r_count != '0);
    assign o_item  = r_q[r_rp];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;
    assign npush   = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign wp1     = i_push.v0 ? r_wp + 1'b1 : r_wp;

    always_comb begin
        n_wp    = r_wp + gb3_pkg::QPW'(npush);
        n_rp    = pop ? r_rp + 1'b1 : r_rp;
        n_count = r_count + gb3_pkg::QCW'(npush) - gb3_pkg::QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_q[r_wp] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_q[wp1] <= i_push.r1;
        end
    end

endmodule

// ===== design/gaussian_blur_3x3_core.sv =====
// 3x3 gaussian blur (1-2-1 kernel, zero padded borders) on a raster pixel stream.
// Accepts one item per clock. Results come out one row and one column behind,
// through the stage 1 and 2 registers; the last item of a row gives
// two results, and an 8-entry output queue absorbs the extra one, so the
// input stalls only when the queue count plus two results for each item in
// flight and the new item could overflow it. The two previous rows live in one
// line memory of MAX_WIDTH entries, read and written back once per item, with
// the write forwarded to a same-address read in the next item (single column
// frames). After the last row the driver sends frame_width flush items as the
// bottom padding row; flush items before that, and pixels during it, are
// dropped. Reset needs no memory clearing pass.
module gaussian_blur_3x3_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  gb3_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output gb3_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [gb3_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [gb3_pkg::CFG_BITS-1:0]        i_cfg_data
);

    localparam int PB = gb3_pkg::PIXEL_BITS;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > gb3_pkg::CFG_BITS) ? CW + 1 : gb3_pkg::CFG_BITS;
    localparam int RB = gb3_pkg::ROW_BITS;
    localparam int SW = PB + 4;
    localparam int SC = gb3_pkg::QCW + 1;

    // configuration
    logic [gb3_pkg::CFG_BITS-1:0]   r_frame_width;
    logic [gb3_pkg::CFG_BITS-1:0]   r_frame_height;
    logic [gb3_pkg::SHIFT_BITS-1:0] r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= gb3_pkg::RESET_FRAME_WIDTH;
            r_frame_height <= gb3_pkg::RESET_FRAME_HEIGHT;
            r_shift        <= gb3_pkg::RESET_SHIFT_AMOUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gb3_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                gb3_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                gb3_pkg::CFG_SHIFT_AMOUNT: r_shift        <= i_cfg_data[gb3_pkg::SHIFT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage 0: accept, position counters, memory read
    logic [CW-1:0] r_col;
    logic [RB-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RB-1:0] n_row;
    logic [WW-1:0] w_raw;
    logic [WW-1:0] w_nz;
    logic [WW-1:0] w_eff;
    logic [RB-1:0] h_eff;
    logic          accept;
    logic          flushing;
    logic          take;
    logic          row_end_now;
    logic [PB-1:0] pix;

    logic          r_s1_v;
    logic [CW-1:0] r_s1_addr;
    logic [PB-1:0] r_s1_p;
    logic          r_s1_first;
    logic          r_s1_r1;
    logic          r_s1_r2;
    logic          r_s1_c1;
    logic          r_s1_end;
    logic          r_s1_fl;
    logic          r_fwd;
    logic [2*PB-1:0] r_fwd_data;

    logic          r_s2_v;
    logic          r_s2_r1;
    logic          r_s2_c1;
    logic          r_s2_end;
    logic          r_s2_fl;

    logic [gb3_pkg::QCW-1:0] q_count;
    logic [SC-1:0]           need;

    assign need = SC'(q_count) + SC'({r_s1_v, 1'b0}) + SC'({r_s2_v, 1'b0}) + SC'(2);
    assign o_in_stall = (need > SC'(gb3_pkg::QDEPTH));
    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        w_raw = WW'(r_frame_width);
        w_nz  = (w_raw == '0) ? WW'(1) : w_raw;
        w_eff = (w_nz > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_nz;
        h_eff = (r_frame_height == '0) ? RB'(1) : RB'(r_frame_height);
        flushing = (r_row >= h_eff);
        take = accept && (i_in_item.action ==
                          (flushing ? gb3_pkg::ACT_FLUSH : gb3_pkg::ACT_PIXEL));
        row_end_now = ((WW'(r_col) + WW'(1)) >= w_eff);
        pix = flushing ? '0 : i_in_item.pixel;
        n_col = r_col;
        n_row = r_row;
        if (take) begin
            if (row_end_now) begin
                n_col = '0;
                n_row = flushing ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // stage 1: window update and line memory write-back
    logic [2*PB-1:0] mem_rdata;
    logic [2*PB-1:0] rd;
    logic [2*PB-1:0] wdata;
    logic [PB-1:0]   top;
    logic [PB-1:0]   mid;
    logic [PB-1:0]   r_win [3][3];

    assign rd    = r_fwd ? r_fwd_data : mem_rdata;
    assign top   = r_s1_r2 ? rd[2*PB-1:PB] : '0;
    assign mid   = r_s1_r1 ? rd[PB-1:0] : '0;
    assign wdata = {rd[PB-1:0], r_s1_p};

    gb3_linemem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (2 * PB)
    ) u_linemem (
        .i_clk   (i_clk),
        .i_re    (take),
        .i_raddr (r_col),
        .o_rdata (mem_rdata),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_addr),
        .i_wdata (wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_s1_v <= take;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_addr  <= r_col;
            r_s1_p     <= pix;
            r_s1_first <= (r_col == '0);
            r_s1_r1    <= (r_row >= RB'(1));
            r_s1_r2    <= (r_row >= RB'(2));
            r_s1_c1    <= (r_col != '0);
            r_s1_end   <= row_end_now;
            r_s1_fl    <= flushing;
            r_fwd      <= r_s1_v && (r_s1_addr == r_col);
            r_fwd_data <= wdata;
        end
        if (r_s1_v) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_s1_first ? '0 : r_win[i][1];
                r_win[i][1] <= r_s1_first ? '0 : r_win[i][2];
            end
            r_win[0][2] <= top;
            r_win[1][2] <= mid;
            r_win[2][2] <= r_s1_p;
            r_s2_r1  <= r_s1_r1;
            r_s2_c1  <= r_s1_c1;
            r_s2_end <= r_s1_end;
            r_s2_fl  <= r_s1_fl;
        end
    end

    // stage 2: kernel sums into the output queue
    logic [PB+1:0]  cs [3];
    logic [SW-1:0]  sum_in;
    logic [SW-1:0]  sum_edge;
    gb3_pkg::t_push push;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            cs[j] = (PB+2)'(r_win[0][j]) + ((PB+2)'(r_win[1][j]) << 1)
                  + (PB+2)'(r_win[2][j]);
        end
        sum_in   = SW'(cs[0]) + (SW'(cs[1]) << 1) + SW'(cs[2]);
        sum_edge = SW'(cs[1]) + (SW'(cs[2]) << 1);
        push.v0           = r_s2_v && r_s2_r1 && r_s2_c1;
        push.r0.blurred   = gb3_pkg::BLUR_BITS'(sum_in >> r_shift);
        push.r0.row_end   = 1'b0;
        push.r0.frame_end = 1'b0;
        push.r0.run_last  = !r_s2_end;
        push.v1           = r_s2_v && r_s2_r1 && r_s2_end;
        push.r1.blurred   = gb3_pkg::BLUR_BITS'(sum_edge >> r_shift);
        push.r1.row_end   = 1'b1;
        push.r1.frame_end = r_s2_fl;
        push.r1.run_last  = 1'b1;
    end

    gb3_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item),
        .o_count (q_count)
    );

endmodule
